FILE: sv/int_to_decimal_ascii_unit_defines.svh
// Assertion macros shared by the conversion unit's modules.
`ifndef INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/i2d_pkg.sv
// Types and constants shared by the decimal text conversion unit.
package i2d_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] NO_SUFFIX  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_SUFFIX
    } state_t;

    typedef enum logic [1:0] {
        SEL_SIGN,
        SEL_DIGIT,
        SEL_SUFFIX
    } char_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      conv_step;
        logic      skip_step;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic bit_last;
        logic top_zero;
        logic dig_one;
        logic neg;
        logic sfx_zero;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/i2d_ctrl.sv
// Sequencing state machine for the decimal text conversion unit.
`include "int_to_decimal_ascii_unit_defines.svh"

module i2d_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output i2d_pkg::dp_cmd_t    cmd,
    input  i2d_pkg::dp_status_t status
);
    import i2d_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_in   = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.skip_step = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_DIGIT;
        cmd.last      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.bit_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, but always keep the final one.
                if (status.top_zero && !status.dig_one)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SIGN;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    cmd.last = status.dig_one && status.sfx_zero;
                    if (status.dig_one)
                    begin
                        state_next = status.sfx_zero ? ST_IDLE : ST_SUFFIX;
                    end
                end
            end
            ST_SUFFIX:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SUFFIX;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `I2D_ASSERT_NEXT(a_conv_holds, (state_reg == ST_CONV) && !status.bit_last, state_reg == ST_CONV, "conversion left early")
    `I2D_ASSERT_NEXT(a_last_ends, cmd.emit && cmd.last, state_reg == ST_IDLE, "text continued after its final character")

endmodule

FILE: sv/i2d_datapath.sv
// Binary to BCD shift-and-add datapath with character output register.
`include "int_to_decimal_ascii_unit_defines.svh"

module i2d_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         value,
    input  logic                kind,
    input  logic [7:0]          suffix,
    input  i2d_pkg::dp_cmd_t    cmd,
    output i2d_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          text_byte,
    output logic                last
);
    import i2d_pkg::*;

    // Decimal digits needed for the largest unsigned value of VALUE_BITS bits.
    localparam int ND  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BW  = 4 * ND;
    localparam int BCW = $clog2(VALUE_BITS + 1);
    localparam int DCW = $clog2(ND + 1);
    localparam int XW  = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    logic [VALUE_BITS-1:0] bin_reg,       bin_next;
    logic [BW-1:0]         bcd_reg,       bcd_next;
    logic [BCW-1:0]        bit_cnt_reg,   bit_cnt_next;
    logic [DCW-1:0]        dig_cnt_reg,   dig_cnt_next;
    logic                  neg_reg,       neg_next;
    logic [7:0]            suffix_reg,    suffix_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            text_byte_reg, text_byte_next;
    logic                  last_reg,      last_next;

    logic [XW-1:0]         value_ext;
    logic [VALUE_BITS-1:0] value_w;
    logic                  in_neg;
    logic [BW-1:0]         bcd_adj;
    logic [3:0]            top_digit;
    logic                  out_free;

    assign value_ext = XW'(value);
    assign value_w   = value_ext[VALUE_BITS-1:0];
    assign in_neg    = kind && value_w[VALUE_BITS-1];
    assign top_digit = bcd_reg[BW-1 -: 4];
    assign out_free  = !out_valid_reg || !out_stall;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                (bcd_reg[4*d +: 4] + 4'd3) : bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        suffix_next    = suffix_reg;
        text_byte_next = text_byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load_in)
        begin
            bin_next     = in_neg ? VALUE_BITS'(~value_w + 1'b1) : value_w;
            bcd_next     = '0;
            bit_cnt_next = BCW'(VALUE_BITS);
            dig_cnt_next = DCW'(ND);
            neg_next     = in_neg;
            suffix_next  = suffix;
        end
        else if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BW-2:0], bin_reg[VALUE_BITS-1]};
            bin_next     = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BCW'(1);
        end
        else if (cmd.skip_step || (cmd.emit && (cmd.sel == SEL_DIGIT)))
        begin
            bcd_next     = {bcd_reg[BW-5:0], 4'h0};
            dig_cnt_next = dig_cnt_reg - DCW'(1);
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.last;
            unique case (cmd.sel)
                SEL_SIGN:   text_byte_next = CHAR_MINUS;
                SEL_DIGIT:  text_byte_next = CHAR_ZERO + {4'h0, top_digit};
                SEL_SUFFIX: text_byte_next = suffix_reg;
                default:    text_byte_next = suffix_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        suffix_reg    <= suffix_next;
        text_byte_reg <= text_byte_next;
        last_reg      <= last_next;
    end

    assign status.bit_last = (bit_cnt_reg == BCW'(1));
    assign status.top_zero = (top_digit == 4'h0);
    assign status.dig_one  = (dig_cnt_reg == DCW'(1));
    assign status.neg      = neg_reg;
    assign status.sfx_zero = (suffix_reg == NO_SUFFIX);
    assign status.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign text_byte = text_byte_reg;
    assign last      = last_reg;

    `I2D_ASSERT_NOW(a_digit_range, cmd.emit && (cmd.sel == SEL_DIGIT), top_digit <= 4'd9, "emitted digit is not decimal")
    `I2D_ASSERT_NEXT(a_conv_top_ok, cmd.conv_step, bcd_reg[BW-1 -: 4] <= 4'd9, "BCD top digit overflowed")
    `I2D_ASSERT_NOW(a_emit_free, cmd.emit, out_free, "character loaded over a waiting one")

endmodule

FILE: sv/int_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII text conversion unit.
//
// The input channel (in_valid, in_stall, value, kind, suffix) takes one
// transaction per value. The low VALUE_BITS bits of value are converted;
// with kind set they are read as two's complement and a negative value is
// preceded by a minus sign. The output channel (out_valid, out_stall,
// text_byte, last) carries one character per transaction, most significant
// digit first, followed by the suffix byte unless the suffix is zero. The
// final character of each value carries last.
// A value is converted by a shift-and-add-three BCD datapath, one input bit
// per cycle. Leading zero digits are then dropped one per cycle. The first
// character is the minus sign or the leading digit. At most ND digits are
// emitted, where ND is the digit count of the widest value (10 at 32 bits).
// in_stall is high while a value is being worked on. A stall on the output
// holds the character in the output register and pauses the sequencer; the
// final character may wait there while the next value is already accepted.
// Reset clears the sequencer and the output valid flag; nothing is emitted.
module int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    input  logic        kind,
    input  logic [7:0]  suffix,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_byte,
    output logic        last
);
    import i2d_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    i2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    i2d_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .kind      (kind),
        .suffix    (suffix),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_byte (text_byte),
        .last      (last)
    );

endmodule
